### src/sgw_pkg.sv
`timescale 1ns / 1ps

package sgw_pkg;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;

	localparam int PIX_W      = 8;
	localparam int LINES      = 4;
	localparam int WIN        = 5;
	localparam int COORD_W    = 10;
	localparam int COORD_MAX  = 1023;
	localparam int OUT_DATA_W = 40;

	// config port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 11;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MODE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 1'd1;
	localparam logic MODE_RST  = 1'b0;
	localparam int   IMG_W_RST = 300;
	localparam int   MIN_WIDTH = 5;

	// window geometry per kernel size
	localparam int K3_LAST = 2;
	localparam int K5_LAST = 4;
	localparam int K3_HALF = 1;
	localparam int K5_HALF = 2;

	// arithmetic
	localparam int SUM_W    = 14;
	localparam int MAG_W    = 13;
	localparam int RECIP_W  = 14;
	localparam int PROD_W   = MAG_W + RECIP_W;
	localparam int RECIP_SH = 19;
	localparam logic [RECIP_W-1:0] RECIP_56 = 14'd9363;
	localparam int DIV8_SH  = 3;
	localparam logic [PIX_W-1:0] OFFSET = 8'h80;

	typedef logic [PIX_W-1:0] pix_t;
	typedef pix_t [WIN-1:0] colv_t;
	typedef colv_t [WIN-1:0] win_t;
	typedef logic [LINES*PIX_W-1:0] line_word_t;
	typedef logic signed [SUM_W-1:0] sum_t;
	typedef logic signed [3:0] coef_t;

	typedef struct packed {
		logic                mode;
		logic [COORD_W-1:0]  row;
		logic [COORD_W-1:0]  col;
	} meta_t;

	typedef struct packed {
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} grad_en_t;

	// 5x5 pair, row 0 is the oldest line, column 0 the oldest pixel
	localparam coef_t K5Y [WIN][WIN] = '{
		'{-4'sd2, -4'sd3, -4'sd4, -4'sd3, -4'sd2},
		'{-4'sd1, -4'sd2, -4'sd3, -4'sd2, -4'sd1},
		'{ 4'sd0,  4'sd0,  4'sd0,  4'sd0,  4'sd0},
		'{ 4'sd1,  4'sd2,  4'sd3,  4'sd2,  4'sd1},
		'{ 4'sd2,  4'sd3,  4'sd4,  4'sd3,  4'sd2}
	};
	localparam coef_t K5X [WIN][WIN] = '{
		'{-4'sd2, -4'sd1,  4'sd0,  4'sd1,  4'sd2},
		'{-4'sd3, -4'sd2,  4'sd0,  4'sd2,  4'sd3},
		'{-4'sd4, -4'sd3,  4'sd0,  4'sd3,  4'sd4},
		'{-4'sd3, -4'sd2,  4'sd0,  4'sd2,  4'sd3},
		'{-4'sd2, -4'sd1,  4'sd0,  4'sd1,  4'sd2}
	};
	// 3x3 pair sits in the newest three rows and columns of the window
	localparam coef_t K3X [WIN][WIN] = '{
		'{ 4'sd0,  4'sd0,  4'sd0,  4'sd0,  4'sd0},
		'{ 4'sd0,  4'sd0,  4'sd0,  4'sd0,  4'sd0},
		'{ 4'sd0,  4'sd0, -4'sd1,  4'sd0,  4'sd1},
		'{ 4'sd0,  4'sd0, -4'sd2,  4'sd0,  4'sd2},
		'{ 4'sd0,  4'sd0, -4'sd1,  4'sd0,  4'sd1}
	};
	localparam coef_t K3Y [WIN][WIN] = '{
		'{ 4'sd0,  4'sd0,  4'sd0,  4'sd0,  4'sd0},
		'{ 4'sd0,  4'sd0,  4'sd0,  4'sd0,  4'sd0},
		'{ 4'sd0,  4'sd0, -4'sd1, -4'sd2, -4'sd1},
		'{ 4'sd0,  4'sd0,  4'sd0,  4'sd0,  4'sd0},
		'{ 4'sd0,  4'sd0,  4'sd1,  4'sd2,  4'sd1}
	};

endpackage

### src/sgw_line_buf.sv
`timescale 1ns / 1ps

module sgw_line_buf #(
	parameter int DEPTH = sgw_pkg::MAX_WIDTH_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rd_en,
	input  logic [AW-1:0]       rd_addr,
	output sgw_pkg::line_word_t rd_col,
	input  logic                wr_en,
	input  logic [AW-1:0]       wr_addr,
	input  sgw_pkg::line_word_t wr_data
);
	import sgw_pkg::*;

	line_word_t mem [DEPTH];
	line_word_t rd_q;
	line_word_t byp_data_q;
	logic       byp_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q       <= mem[rd_addr];
			byp_data_q <= wr_data;
		end
	end

	// same column written and read in one cycle: take the new word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else if (rd_en) begin
			byp_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_col = byp_q ? byp_data_q : rd_q;

endmodule

### src/sgw_window.sv
`timescale 1ns / 1ps

module sgw_window (
	input  logic           clk,
	input  logic           shift_en,
	input  sgw_pkg::colv_t colv,
	output sgw_pkg::win_t  win
);
	import sgw_pkg::*;

	win_t win_q;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			for (int r = 0; r < WIN; r++) begin
				for (int k = 0; k < WIN - 1; k++) begin
					win_q[r][k] <= win_q[r][k+1];
				end
				win_q[r][WIN-1] <= colv[r];
			end
		end
	end

	assign win = win_q;

endmodule

### src/sgw_grad.sv
`timescale 1ns / 1ps

module sgw_grad (
	input  logic                   clk,
	input  sgw_pkg::grad_en_t      en,
	input  sgw_pkg::win_t          win,
	input  sgw_pkg::meta_t         meta_in,
	output logic [sgw_pkg::PIX_W-1:0] grad_first,
	output logic [sgw_pkg::PIX_W-1:0] grad_second,
	output sgw_pkg::meta_t         meta_out
);
	import sgw_pkg::*;

	sum_t part [2][WIN];
	sum_t part_s3 [2][WIN];
	sum_t tot [2];
	sum_t tot_s4 [2];
	logic [MAG_W-1:0]  mag [2];
	logic [MAG_W-1:0]  mag_s5 [2];
	logic [PROD_W-1:0] prod_s5 [2];
	logic              neg_s5 [2];
	logic [PIX_W-1:0]  quo [2];
	logic [PIX_W-1:0]  res [2];
	logic [PIX_W-1:0]  res_s6 [2];
	meta_t meta_s3, meta_s4, meta_s5, meta_s6;

	// row partial sums of both kernels
	// 3x3 mode only looks at the newest three rows and columns
	always_comb begin
		for (int r = 0; r < WIN; r++) begin
			part[0][r] = '0;
			part[1][r] = '0;
			for (int c = 0; c < WIN; c++) begin
				if (meta_in.mode || (r >= WIN - 1 - K3_LAST && c >= WIN - 1 - K3_LAST)) begin
					part[0][r] = part[0][r]
						+ sum_t'(meta_in.mode ? K5Y[r][c] : K3X[r][c])
						* sum_t'({1'b0, win[r][c]});
					part[1][r] = part[1][r]
						+ sum_t'(meta_in.mode ? K5X[r][c] : K3Y[r][c])
						* sum_t'({1'b0, win[r][c]});
				end
			end
		end
	end

	always_comb begin
		for (int g = 0; g < 2; g++) begin
			tot[g] = '0;
			for (int r = 0; r < WIN; r++) begin
				tot[g] = tot[g] + part_s3[g][r];
			end
			mag[g] = MAG_W'(tot_s4[g][SUM_W-1] ? -tot_s4[g] : tot_s4[g]);
		end
	end

	// divide magnitude so the quotient truncates toward zero, restore sign, add 128
	always_comb begin
		for (int g = 0; g < 2; g++) begin
			quo[g] = meta_s5.mode ? prod_s5[g][RECIP_SH +: PIX_W] : mag_s5[g][DIV8_SH +: PIX_W];
			res[g] = (neg_s5[g] ? -quo[g] : quo[g]) ^ OFFSET;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			part_s3 <= part;
			meta_s3 <= meta_in;
		end
		if (en.s4) begin
			tot_s4  <= tot;
			meta_s4 <= meta_s3;
		end
		if (en.s5) begin
			for (int g = 0; g < 2; g++) begin
				mag_s5[g]  <= mag[g];
				prod_s5[g] <= PROD_W'(mag[g]) * PROD_W'(RECIP_56);
				neg_s5[g]  <= tot_s4[g][SUM_W-1];
			end
			meta_s5 <= meta_s4;
		end
		if (en.s6) begin
			res_s6  <= res;
			meta_s6 <= meta_s5;
		end
	end

	assign grad_first  = res_s6[0];
	assign grad_second = res_s6[1];
	assign meta_out    = meta_s6;

endmodule

### src/sobel_gradient_window_filter.sv
`timescale 1ns / 1ps

// Streaming Sobel gradient filter over 8-bit grayscale pixels in raster order.
// s_axis carries one pixel a beat; tuser high marks the first pixel of a frame.
// m_axis carries one result beat for each pixel that completes a full window:
// both kernel sums divided (by 8 for 3x3, by 56 for 5x5) and offset by 128,
// plus the row and column of the window centre. Border pixels give no beat.
// The cfg channel writes kernel_mode (index 0) and image_width (index 1); it is
// always ready and should only be written while no pixel is in flight.
// Throughput is one pixel per cycle: the line store is a single memory with
// one read and one write port, the column read at accept and written back one
// stage later. A result beat leaves the output register after the window and
// gradient stages. Stages advance independently, so bubbles close up and input
// is still taken while a result waits; with the output stalled and the
// pipeline full, s_axis_tready drops. Reset clears counters, stage valids and
// the registers to mode 0 and width 300 (clamped to MAX_WIDTH); the line store
// needs no clearing since border gating never reads an unwritten column.
module sobel_gradient_window_filter #(
	parameter int MAX_WIDTH  = sgw_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = sgw_pkg::MAX_HEIGHT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [sgw_pkg::PIX_W-1:0]         s_axis_tdata,  // pixel
	input  logic                              s_axis_tuser,  // frame_start
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// grad_first, grad_second, center_row, center_col, zero pad
	output logic [sgw_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [sgw_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sgw_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import sgw_pkg::*;

	localparam int CW   = $clog2(MAX_WIDTH + 1);
	localparam int AW   = $clog2(MAX_WIDTH);
	localparam int RW   = $clog2(MAX_HEIGHT);
	localparam int WXW  = (CW > CFG_DATA_W) ? CW : CFG_DATA_W;
	localparam int RXW  = (RW > COORD_W) ? RW : COORD_W;
	localparam int CXW  = (CW > COORD_W) ? CW : COORD_W;
	localparam int W_RST = (IMG_W_RST > MAX_WIDTH) ? MAX_WIDTH : IMG_W_RST;

	function automatic logic [RW-1:0] row_step(input logic [RW-1:0] r);
		return (r < RW'(MAX_HEIGHT - 1)) ? r + 1'b1 : r;
	endfunction

	logic          mode_q;
	logic [CW-1:0] w_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;

	logic cfg_we, accept;
	logic [WXW-1:0] wcfg;
	logic [CW-1:0]  w_new;

	logic [CW-1:0] col_a, col_c, col_n, cc;
	logic [RW-1:0] row_a, row_c, rc;
	logic [RXW-1:0] rce;
	logic [CXW-1:0] cce;
	logic wrap0, wrap1, prod_a;
	meta_t meta_a;

	logic v1, v2, v3, v4, v5, v6;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
	pix_t         pix_s1;
	logic [AW-1:0] addr_s1;
	logic         prod_s1, prod_s2;
	meta_t        meta_s1, meta_s2, meta_o;

	line_word_t rd_col, wr_word;
	logic       shift_en;
	colv_t      colv;
	win_t       win;
	grad_en_t   gen;
	pix_t       grad_first, grad_second;

	// configuration
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign wcfg      = WXW'(cfg_data);
	assign w_new     = (wcfg < WXW'(MIN_WIDTH)) ? CW'(MIN_WIDTH) :
	                   (wcfg > WXW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(wcfg);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_RST;
			w_q    <= CW'(W_RST);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KERNEL_MODE: mode_q <= cfg_data[0];
				REG_IMAGE_WIDTH: w_q    <= w_new;
				default: ;
			endcase
		end
	end

	// position of the incoming pixel
	always_comb begin
		col_a  = s_axis_tuser ? '0 : col_q;
		row_a  = s_axis_tuser ? '0 : row_q;
		wrap0  = col_a >= w_q;
		col_c  = wrap0 ? '0 : col_a;
		row_c  = wrap0 ? row_step(row_a) : row_a;
		col_n  = col_c + 1'b1;
		wrap1  = col_n >= w_q;
		prod_a = (row_c >= RW'(mode_q ? K5_LAST : K3_LAST)) &&
		         (col_c >= CW'(mode_q ? K5_LAST : K3_LAST));
		rc     = row_c - RW'(mode_q ? K5_HALF : K3_HALF);
		cc     = col_c - CW'(mode_q ? K5_HALF : K3_HALF);
		rce    = RXW'(rc);
		cce    = CXW'(cc);
		meta_a.mode = mode_q;
		meta_a.row  = (rce > RXW'(COORD_MAX)) ? COORD_W'(COORD_MAX) : rce[COORD_W-1:0];
		meta_a.col  = (cce > CXW'(COORD_MAX)) ? COORD_W'(COORD_MAX) : cce[COORD_W-1:0];
	end

	// stage handshakes, each stage moves when the one after it has room
	assign rdy6 = !v6 || m_axis_tready;
	assign rdy5 = !v5 || rdy6;
	assign rdy4 = !v4 || rdy5;
	assign rdy3 = !v3 || rdy4;
	assign rdy2 = !v2 || rdy3;
	assign rdy1 = !v1 || rdy2;

	assign s_axis_tready = rdy1;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign shift_en      = v1 && rdy2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			v1 <= 1'b0;
			v2 <= 1'b0;
			v3 <= 1'b0;
			v4 <= 1'b0;
			v5 <= 1'b0;
			v6 <= 1'b0;
		end else begin
			if (accept) begin
				col_q <= wrap1 ? '0 : col_n;
				row_q <= wrap1 ? row_step(row_c) : row_c;
			end
			if (rdy1) v1 <= s_axis_tvalid;
			if (rdy2) v2 <= v1;
			if (rdy3) v3 <= v2 && prod_s2;
			if (rdy4) v4 <= v3;
			if (rdy5) v5 <= v4;
			if (rdy6) v6 <= v5;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1  <= s_axis_tdata;
			addr_s1 <= col_c[AW-1:0];
			prod_s1 <= prod_a;
			meta_s1 <= meta_a;
		end
		if (rdy2) begin
			prod_s2 <= prod_s1;
			meta_s2 <= meta_s1;
		end
	end

	// column vector: entry 0 is four rows up, the last entry is the new pixel
	always_comb begin
		colv[WIN-1] = pix_s1;
		for (int i = 0; i < LINES; i++) begin
			colv[LINES-1-i] = rd_col[i*PIX_W +: PIX_W];
		end
	end
	assign wr_word = {rd_col[(LINES-1)*PIX_W-1:0], pix_s1};

	sgw_line_buf #(
		.DEPTH (MAX_WIDTH)
	) u_line_buf (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (col_c[AW-1:0]),
		.rd_col  (rd_col),
		.wr_en   (shift_en),
		.wr_addr (addr_s1),
		.wr_data (wr_word)
	);

	sgw_window u_window (
		.clk      (clk),
		.shift_en (shift_en),
		.colv     (colv),
		.win      (win)
	);

	assign gen.s3 = rdy3;
	assign gen.s4 = rdy4;
	assign gen.s5 = rdy5;
	assign gen.s6 = rdy6;

	sgw_grad u_grad (
		.clk         (clk),
		.en          (gen),
		.win         (win),
		.meta_in     (meta_s2),
		.grad_first  (grad_first),
		.grad_second (grad_second),
		.meta_out    (meta_o)
	);

	assign m_axis_tvalid = v6;
	assign m_axis_tdata  = {{(OUT_DATA_W - 2*PIX_W - 2*COORD_W){1'b0}},
	                        meta_o.col, meta_o.row, grad_second, grad_first};

	// column counter stays inside the row after every pixel taken with no cfg write
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !cfg_we) |=> (col_q < w_q))
		else $error("column count past image width");

	assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= RW'(MAX_HEIGHT - 1))
		else $error("row count past saturation");

	// an item held in the first stage is not lost while the window stalls
	assert property (@(posedge clk) disable iff (!arst_n)
		(v1 && !rdy2) |=> (v1 && $stable(addr_s1)))
		else $error("stalled pixel dropped from first stage");

endmodule
